/* design/npgc_pkg.sv */
`timescale 1ns / 1ps
// Shared types, constants and the arctangent table for the nearest point search.
// No dependencies; every other file of the block imports this package.
package npgc_pkg;

    localparam int LAT_W   = 30;
    localparam int LON_W   = 31;
    localparam int CLASS_W = 2;
    localparam int NUM_W   = 16;
    localparam int DIST_W  = 29;
    localparam int CFG_W   = 31;

    // Datapath width of the CORDIC lanes (Q30 values with headroom)
    localparam int CW = 36;

    // Number of angle lanes and their roles
    localparam int LANES = 4;
    localparam int LANE_DLAT = 0;
    localparam int LANE_DLON = 1;
    localparam int LANE_PLAT = 2;
    localparam int LANE_QLAT = 3;

    // Configuration register indexes
    localparam logic [0:0] REG_QUERY_LATITUDE  = 1'b0;
    localparam logic [0:0] REG_QUERY_LONGITUDE = 1'b1;

    localparam logic signed [32:0] DEG90_Q23  = 33'sd754974720;
    localparam logic signed [32:0] DEG180_Q23 = 33'sd1509949440;
    localparam logic [26:0]        DEG_TO_RAD_MUL = 27'd74961321;
    localparam logic signed [CW-1:0] CORDIC_GAIN_INV = 36'sd652032874;
    localparam logic [30:0]        ONE_Q30 = 31'd1073741824;
    localparam logic [63:0]        TWO_RADIUS = 64'd12742000;
    localparam logic [DIST_W-1:0]  DIST_MAX = {DIST_W{1'b1}};

    typedef struct packed {
        logic        neg;
        logic        flip;
        logic [29:0] mag;
    } t_red;

    typedef struct packed {
        logic [LANES-1:0][31:0] ang;
        logic [LANES-1:0]       flip;
        logic [CLASS_W-1:0]     point_class;
        logic [NUM_W-1:0]       point_number;
        logic                   final_point;
    } t_job;

    typedef enum logic [3:0] {
        BS_IDLE,
        BS_ROT,
        BS_MUL1,
        BS_MUL2,
        BS_SUM,
        BS_SQRT,
        BS_VEC,
        BS_DIST1,
        BS_DIST2,
        BS_UPDATE
    } t_back_state;

    // Arctangent of 2^-i in radians Q30, truncated
    function automatic logic signed [CW-1:0] arc_angle(input logic [4:0] i);
        logic [31:0] v;
        case (i)
            5'd0:  v = 32'h3243F6A8;
            5'd1:  v = 32'h1DAC6705;
            5'd2:  v = 32'h0FADBAFC;
            5'd3:  v = 32'h07F56EA6;
            5'd4:  v = 32'h03FEAB76;
            5'd5:  v = 32'h01FFD55B;
            5'd6:  v = 32'h00FFFAAA;
            5'd7:  v = 32'h007FFF55;
            5'd8:  v = 32'h003FFFEA;
            5'd9:  v = 32'h001FFFFD;
            5'd10: v = 32'h000FFFFF;
            5'd11: v = 32'h0007FFFF;
            5'd12: v = 32'h0003FFFF;
            5'd13: v = 32'h0001FFFF;
            5'd14: v = 32'h0000FFFF;
            5'd15: v = 32'h00007FFF;
            5'd16: v = 32'h00003FFF;
            5'd17: v = 32'h00001FFF;
            5'd18: v = 32'h00000FFF;
            5'd19: v = 32'h000007FF;
            5'd20: v = 32'h000003FF;
            5'd21: v = 32'h000001FF;
            5'd22: v = 32'h000000FF;
            5'd23: v = 32'h0000007F;
            5'd24: v = 32'h0000003F;
            5'd25: v = 32'h0000001F;
            5'd26: v = 32'h0000000F;
            5'd27: v = 32'h00000008;
            5'd28: v = 32'h00000004;
            5'd29: v = 32'h00000002;
            5'd30: v = 32'h00000001;
            default: v = 32'h00000000;
        endcase
        return $signed({4'b0000, v});
    endfunction

endpackage

/* design/npgc_point_if.sv */
`timescale 1ns / 1ps
// Candidate word channel: valid/ready handshake with the candidate fields.
// Depends on npgc_pkg for field widths.
interface npgc_point_if;
    import npgc_pkg::*;

    logic                      valid;
    logic                      ready;
    logic signed [LAT_W-1:0]   point_latitude;
    logic signed [LON_W-1:0]   point_longitude;
    logic [CLASS_W-1:0]        point_class;
    logic [NUM_W-1:0]          point_number;
    logic                      final_point;

    modport source (
        output valid, point_latitude, point_longitude, point_class, point_number,
               final_point,
        input  ready
    );
    modport sink (
        input  valid, point_latitude, point_longitude, point_class, point_number,
               final_point,
        output ready
    );
endinterface

/* design/npgc_result_if.sv */
`timescale 1ns / 1ps
// Result word channel: valid/ready handshake with the nearest candidate fields.
// Depends on npgc_pkg for field widths.
interface npgc_result_if;
    import npgc_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [CLASS_W-1:0]   nearest_class;
    logic [NUM_W-1:0]     nearest_number;
    logic [DIST_W-1:0]    nearest_distance;

    modport source (
        output valid, nearest_class, nearest_number, nearest_distance,
        input  ready
    );
    modport sink (
        input  valid, nearest_class, nearest_number, nearest_distance,
        output ready
    );
endinterface

/* design/npgc_front.sv */
`timescale 1ns / 1ps
// Front end: accepts candidate words, reduces the four angles and converts them
// to radians Q30. Depends on npgc_pkg and npgc_point_if.
module npgc_front (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic signed [29:0]              i_query_latitude,
    input  logic signed [30:0]              i_query_longitude,
    npgc_point_if.sink                      i_point,
    output npgc_pkg::t_job                  o_job,
    output logic                            o_job_valid,
    input  logic                            i_job_ready
);
    import npgc_pkg::*;

    // Fold an angle into [-90, 90] degrees, flipping sine and cosine
    function automatic t_red reduce(input logic signed [32:0] d);
        t_red             r;
        logic signed [32:0] d2;
        d2 = d;
        r.flip = 1'b0;
        if (d > DEG90_Q23) begin
            d2 = d - DEG180_Q23;
            r.flip = 1'b1;
        end else if (d < -DEG90_Q23) begin
            d2 = d + DEG180_Q23;
            r.flip = 1'b1;
        end
        r.neg = d2[32];
        r.mag = r.neg ? 30'(-d2) : 30'(d2);
        return r;
    endfunction

    logic                   r_s1_valid, n_s1_valid;
    logic                   r_s2_valid, n_s2_valid;
    t_red                   r_s1_red [LANES];
    logic [CLASS_W-1:0]     r_s1_class;
    logic [NUM_W-1:0]       r_s1_number;
    logic                   r_s1_final;
    t_job                   r_s2_job;

    logic                   w_s1_adv, w_s2_adv;
    logic signed [32:0]     w_d [LANES];
    logic [56:0]            w_prod [LANES];

    // Stage advance: a stage moves when the one after it has room
    assign w_s2_adv      = !r_s2_valid || i_job_ready;
    assign w_s1_adv      = !r_s1_valid || w_s2_adv;
    assign i_point.ready = w_s1_adv;
    assign o_job_valid   = r_s2_valid;
    assign o_job         = r_s2_job;

    // Angle differences in degrees * 2^23
    assign w_d[LANE_DLAT] = 33'(i_query_latitude) - 33'(i_point.point_latitude);
    assign w_d[LANE_DLON] = 33'(i_query_longitude) - 33'(i_point.point_longitude);
    assign w_d[LANE_PLAT] = 33'(i_point.point_latitude) <<< 1;
    assign w_d[LANE_QLAT] = 33'(i_query_latitude) <<< 1;

    always_comb begin
        for (int k = 0; k < LANES; k++) begin
            w_prod[k] = 57'(r_s1_red[k].mag) * 57'(DEG_TO_RAD_MUL);
        end
    end

    always_comb begin
        n_s1_valid = r_s1_valid;
        n_s2_valid = r_s2_valid;
        if (w_s2_adv) begin
            n_s2_valid = r_s1_valid;
        end
        if (w_s1_adv) begin
            n_s1_valid = i_point.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            r_s1_valid <= n_s1_valid;
            r_s2_valid <= n_s2_valid;
        end
    end

    // Stage one: reduce angles and hold the tags
    always_ff @(posedge i_clk) begin
        if (w_s1_adv && i_point.valid) begin
            for (int k = 0; k < LANES; k++) begin
                r_s1_red[k] <= reduce(w_d[k]);
            end
            r_s1_class  <= i_point.point_class;
            r_s1_number <= i_point.point_number;
            r_s1_final  <= i_point.final_point;
        end
    end

    // Stage two: scale to radians Q30 and apply the sign
    always_ff @(posedge i_clk) begin
        if (w_s2_adv && r_s1_valid) begin
            for (int k = 0; k < LANES; k++) begin
                r_s2_job.ang[k]  <= r_s1_red[k].neg ? -w_prod[k][56:25] : w_prod[k][56:25];
                r_s2_job.flip[k] <= r_s1_red[k].flip;
            end
            r_s2_job.point_class  <= r_s1_class;
            r_s2_job.point_number <= r_s1_number;
            r_s2_job.final_point  <= r_s1_final;
        end
    end

endmodule

/* design/npgc_queue.sv */
`timescale 1ns / 1ps
// Two-entry job queue between the front end and the distance engine.
// Depends on npgc_pkg for the job type.
module npgc_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  npgc_pkg::t_job  i_push_job,
    input  logic            i_push,
    output logic            o_full,
    output npgc_pkg::t_job  o_pop_job,
    input  logic            i_pop,
    output logic            o_empty
);
    import npgc_pkg::*;

    t_job         r_mem [2];
    logic         r_wr_ptr, r_rd_ptr;
    logic [1:0]   r_count;

    assign o_full    = (r_count == 2'd2);
    assign o_empty   = (r_count == 2'd0);
    assign o_pop_job = r_mem[r_rd_ptr];

    // Advance pointers and track fill
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            r_count <= r_count + 2'(i_push) - 2'(i_pop);
        end
    end

    // Store the pushed word
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_job;
        end
    end

endmodule

/* design/npgc_back.sv */
`timescale 1ns / 1ps
// Distance engine: four CORDIC rotation lanes, haversine term, two bit-serial
// square roots, CORDIC vectoring, scaling and the nearest search. Depends on
// npgc_pkg and npgc_result_if.
module npgc_back #(
    parameter int CORDIC_STEPS = 24,
    parameter int DISTANCE_FRACTION_BITS = 4
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  npgc_pkg::t_job          i_job,
    input  logic                    i_job_valid,
    output logic                    o_job_pop,
    npgc_result_if.source           o_result,
    output npgc_pkg::t_back_state   o_state
);
    import npgc_pkg::*;

    localparam int CNT_W = ($clog2(CORDIC_STEPS) > 5) ? $clog2(CORDIC_STEPS) : 5;
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(CORDIC_STEPS - 1);
    localparam logic [CNT_W-1:0] LAST_ROOT = CNT_W'(30);
    localparam logic [31:0] DIST_SCALE = 32'(TWO_RADIUS << DISTANCE_FRACTION_BITS);

    t_back_state               r_state, n_state;
    logic [CNT_W-1:0]          r_cnt;

    logic signed [CW-1:0]      r_x [LANES];
    logic signed [CW-1:0]      r_y [LANES];
    logic signed [CW-1:0]      r_z [LANES];
    logic [LANES-1:0]          r_flip;
    logic [CLASS_W-1:0]        r_class;
    logic [NUM_W-1:0]          r_number;
    logic                      r_final;

    logic signed [63:0]        r_pll, r_pcc, r_poo;
    logic signed [67:0]        r_pm;
    logic [61:0]               r_sv [2];
    logic [61:0]               r_sr [2];
    logic [61:0]               r_bit;
    logic signed [CW-1:0]      r_vx, r_vy, r_vz;
    logic [62:0]               r_prod;
    logic [DIST_W-1:0]         r_dist;

    logic [DIST_W-1:0]         r_best_dist;
    logic [CLASS_W-1:0]        r_best_class;
    logic [NUM_W-1:0]          r_best_number;
    logic                      r_have_best;

    logic                      r_out_valid;
    logic [CLASS_W-1:0]        r_out_class;
    logic [NUM_W-1:0]          r_out_number;
    logic [DIST_W-1:0]         r_out_dist;

    logic                      w_step_done, w_root_done, w_out_free;
    logic                      w_commit, w_emit, w_take;
    logic [4:0]                w_sh;
    logic signed [31:0]        w_sl, w_so, w_c1, w_c2;
    logic signed [33:0]        w_cc30, w_oo30;
    logic signed [38:0]        w_asum;
    logic [30:0]               w_a;
    logic [61:0]               w_sv_next [2];
    logic [61:0]               w_sr_next [2];
    logic [30:0]               w_zc;
    logic [32:0]               w_p;
    logic [DIST_W-1:0]         w_new_dist;
    logic [CLASS_W-1:0]        w_new_class;
    logic [NUM_W-1:0]          w_new_number;

    assign w_sh        = r_cnt[4:0];
    assign w_step_done = (r_cnt == LAST_STEP);
    assign w_root_done = (r_cnt == LAST_ROOT);
    assign w_out_free  = !r_out_valid || o_result.ready;
    assign o_state     = r_state;

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            BS_IDLE:   if (i_job_valid) begin
                n_state = BS_ROT;
            end
            BS_ROT:    if (w_step_done) begin
                n_state = BS_MUL1;
            end
            BS_MUL1:   n_state = BS_MUL2;
            BS_MUL2:   n_state = BS_SUM;
            BS_SUM:    n_state = BS_SQRT;
            BS_SQRT:   if (w_root_done) begin
                n_state = BS_VEC;
            end
            BS_VEC:    if (w_step_done) begin
                n_state = BS_DIST1;
            end
            BS_DIST1:  n_state = BS_DIST2;
            BS_DIST2:  n_state = BS_UPDATE;
            BS_UPDATE: if (w_commit) begin
                n_state = BS_IDLE;
            end
            default:   n_state = BS_IDLE;
        endcase
    end

    // Control outputs
    always_comb begin
        o_job_pop = 1'b0;
        w_commit  = 1'b0;
        case (r_state)
            BS_IDLE:   o_job_pop = i_job_valid;
            BS_UPDATE: w_commit  = !r_final || w_out_free;
            default: begin
                o_job_pop = 1'b0;
                w_commit  = 1'b0;
            end
        endcase
        w_emit = w_commit && r_final;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BS_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            if (n_state != r_state) begin
                r_cnt <= '0;
            end else begin
                r_cnt <= r_cnt + 1'b1;
            end
        end
    end

    // Haversine operands, sign-corrected after the reduction
    assign w_sl = r_flip[LANE_DLAT] ? 32'(-r_y[LANE_DLAT]) : 32'(r_y[LANE_DLAT]);
    assign w_so = r_flip[LANE_DLON] ? 32'(-r_y[LANE_DLON]) : 32'(r_y[LANE_DLON]);
    assign w_c1 = r_flip[LANE_PLAT] ? 32'(-r_x[LANE_PLAT]) : 32'(r_x[LANE_PLAT]);
    assign w_c2 = r_flip[LANE_QLAT] ? 32'(-r_x[LANE_QLAT]) : 32'(r_x[LANE_QLAT]);
    assign w_cc30 = 34'(r_pcc >>> 30);
    assign w_oo30 = 34'(r_poo >>> 30);
    assign w_asum = 39'(r_pll >>> 30) + 39'(r_pm >>> 30);

    // Clamp the haversine term to [0, 1]
    always_comb begin
        if (w_asum < 0) begin
            w_a = '0;
        end else if (w_asum > $signed({8'd0, ONE_Q30})) begin
            w_a = ONE_Q30;
        end else begin
            w_a = w_asum[30:0];
        end
    end

    // One digit of both square roots
    always_comb begin
        for (int k = 0; k < 2; k++) begin
            if (r_sv[k] >= r_sr[k] + r_bit) begin
                w_sv_next[k] = r_sv[k] - (r_sr[k] + r_bit);
                w_sr_next[k] = (r_sr[k] >> 1) + r_bit;
            end else begin
                w_sv_next[k] = r_sv[k];
                w_sr_next[k] = r_sr[k] >> 1;
            end
        end
    end

    // Scale the central angle to distance and saturate
    assign w_zc = r_vz[CW-1] ? 31'd0 : r_vz[30:0];
    assign w_p  = 33'((r_prod + 63'(64'd1 << 29)) >> 30);

    // Keep the nearest candidate; the first one is always taken and an earlier one wins ties
    assign w_take       = !r_have_best || (r_dist < r_best_dist);
    assign w_new_dist   = w_take ? r_dist   : r_best_dist;
    assign w_new_class  = w_take ? r_class  : r_best_class;
    assign w_new_number = w_take ? r_number : r_best_number;

    // Datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            BS_IDLE: begin
                for (int k = 0; k < LANES; k++) begin
                    r_x[k] <= CORDIC_GAIN_INV;
                    r_y[k] <= '0;
                    r_z[k] <= CW'($signed(i_job.ang[k]));
                end
                r_flip   <= i_job.flip;
                r_class  <= i_job.point_class;
                r_number <= i_job.point_number;
                r_final  <= i_job.final_point;
            end
            BS_ROT: begin
                for (int k = 0; k < LANES; k++) begin
                    if (!r_z[k][CW-1]) begin
                        r_x[k] <= r_x[k] - (r_y[k] >>> w_sh);
                        r_y[k] <= r_y[k] + (r_x[k] >>> w_sh);
                        r_z[k] <= r_z[k] - arc_angle(w_sh);
                    end else begin
                        r_x[k] <= r_x[k] + (r_y[k] >>> w_sh);
                        r_y[k] <= r_y[k] - (r_x[k] >>> w_sh);
                        r_z[k] <= r_z[k] + arc_angle(w_sh);
                    end
                end
            end
            BS_MUL1: begin
                r_pll <= w_sl * w_sl;
                r_pcc <= w_c1 * w_c2;
                r_poo <= w_so * w_so;
            end
            BS_MUL2: begin
                r_pm <= 68'(w_cc30) * 68'(w_oo30);
            end
            BS_SUM: begin
                r_sv[0] <= 62'(ONE_Q30 - w_a) << 30;
                r_sv[1] <= 62'(w_a) << 30;
                r_sr[0] <= '0;
                r_sr[1] <= '0;
                r_bit   <= 62'(64'd1 << 60);
            end
            BS_SQRT: begin
                for (int k = 0; k < 2; k++) begin
                    r_sv[k] <= w_sv_next[k];
                    r_sr[k] <= w_sr_next[k];
                end
                r_bit <= r_bit >> 2;
                if (w_root_done) begin
                    r_vx <= $signed({5'd0, w_sr_next[0][30:0]});
                    r_vy <= $signed({5'd0, w_sr_next[1][30:0]});
                    r_vz <= '0;
                end
            end
            BS_VEC: begin
                if (!r_vy[CW-1]) begin
                    r_vx <= r_vx + (r_vy >>> w_sh);
                    r_vy <= r_vy - (r_vx >>> w_sh);
                    r_vz <= r_vz + arc_angle(w_sh);
                end else begin
                    r_vx <= r_vx - (r_vy >>> w_sh);
                    r_vy <= r_vy + (r_vx >>> w_sh);
                    r_vz <= r_vz - arc_angle(w_sh);
                end
            end
            BS_DIST1: begin
                r_prod <= 63'(w_zc) * 63'(DIST_SCALE);
            end
            BS_DIST2: begin
                r_dist <= (w_p > 33'(DIST_MAX)) ? DIST_MAX : w_p[DIST_W-1:0];
            end
            default: begin
                r_dist <= r_dist;
            end
        endcase
    end

    // Search state: update on commit, clear after a final word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_best_dist   <= DIST_MAX;
            r_best_class  <= '0;
            r_best_number <= '0;
            r_have_best   <= 1'b0;
        end else if (w_commit) begin
            if (r_final) begin
                r_best_dist   <= DIST_MAX;
                r_best_class  <= '0;
                r_best_number <= '0;
                r_have_best   <= 1'b0;
            end else begin
                r_best_dist   <= w_new_dist;
                r_best_class  <= w_new_class;
                r_best_number <= w_new_number;
                r_have_best   <= 1'b1;
            end
        end
    end

    // Output register: hold the word until the receiver takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_emit) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_out_class  <= w_new_class;
            r_out_number <= w_new_number;
            r_out_dist   <= w_new_dist;
        end
    end

    assign o_result.valid            = r_out_valid;
    assign o_result.nearest_class    = r_out_class;
    assign o_result.nearest_number   = r_out_number;
    assign o_result.nearest_distance = r_out_dist;

endmodule

/* design/nearest_point_great_circle.sv */
`timescale 1ns / 1ps
// Nearest candidate to a query position by haversine great-circle distance.
// Usage:
//   Write the query latitude (index 0) and longitude (index 1) on the config
//   port while the block is idle; both are degrees * 2^22, signed.
//   Send candidate words on i_point; each carries a position, a class, a number
//   and a final flag. The block keeps the nearest candidate (first wins ties)
//   and, on the final word, puts class, number and distance (metres * 2^F,
//   saturating) on o_result, then clears its search state.
// Timing:
//   The front end takes one word per cycle, while the queue has room, through its
//   reduction and scaling stages into a two-entry queue. The distance engine then
//   works on one word at a time: the rotation lanes, the multiplies, the bit-serial
//   square roots, the vectoring loop, the scaling and the search update.
//   The result is registered in the output register when the final word commits.
// Reset and stall:
//   Reset clears the query registers to zero and empties queue and search.
//   A result waits in the output register while the receiver stalls; the
//   engine holds on the next final word until the register is free, and the
//   input side keeps filling the queue meanwhile.
// Depends on npgc_pkg, the two channel interfaces, npgc_front, npgc_queue, npgc_back.
module nearest_point_great_circle #(
    parameter int CORDIC_STEPS = 24,
    parameter int DISTANCE_FRACTION_BITS = 4
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_wr_en,
    input  logic [0:0]                  i_cfg_index,
    input  logic [npgc_pkg::CFG_W-1:0]  i_cfg_data,
    npgc_point_if.sink                  i_point,
    npgc_result_if.source               o_result
);
    import npgc_pkg::*;

    logic signed [LAT_W-1:0]  r_query_lat;
    logic signed [LON_W-1:0]  r_query_lon;

    t_job         w_front_job, w_back_job;
    logic         w_front_valid, w_queue_full, w_queue_empty, w_job_pop;
    t_back_state  w_back_state;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_query_lat <= '0;
            r_query_lon <= '0;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                REG_QUERY_LATITUDE:  r_query_lat <= i_cfg_data[LAT_W-1:0];
                REG_QUERY_LONGITUDE: r_query_lon <= i_cfg_data[LON_W-1:0];
                default:             r_query_lat <= r_query_lat;
            endcase
        end
    end

    npgc_front u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_query_latitude  (r_query_lat),
        .i_query_longitude (r_query_lon),
        .i_point           (i_point),
        .o_job             (w_front_job),
        .o_job_valid       (w_front_valid),
        .i_job_ready       (!w_queue_full)
    );

    npgc_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push_job (w_front_job),
        .i_push     (w_front_valid && !w_queue_full),
        .o_full     (w_queue_full),
        .o_pop_job  (w_back_job),
        .i_pop      (w_job_pop),
        .o_empty    (w_queue_empty)
    );

    npgc_back #(
        .CORDIC_STEPS           (CORDIC_STEPS),
        .DISTANCE_FRACTION_BITS (DISTANCE_FRACTION_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job       (w_back_job),
        .i_job_valid (!w_queue_empty),
        .o_job_pop   (w_job_pop),
        .o_result    (o_result),
        .o_state     (w_back_state)
    );

    // The engine only takes a job that is in the queue
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_job_pop |-> !w_queue_empty)
        else $error("job taken from an empty queue");

    // A result only appears after a search step commits
    a_result_from_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_result.valid) |-> $past(w_back_state == BS_UPDATE))
        else $error("result raised outside the update step");

    // The front end is open for words right after reset
    a_ready_after_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> i_point.ready)
        else $error("input not ready after reset");

endmodule

/* tb/sv/npgc_scoreboard.sv */
`timescale 1ns / 1ps
// Checker for the nearest point search: watches both channels, predicts the
// winner of each search and compares results. Depends on npgc_pkg and both interfaces.
module npgc_scoreboard (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_wr_en,
    input  logic [0:0]                i_cfg_index,
    input  logic [npgc_pkg::CFG_W-1:0] i_cfg_data,
    npgc_point_if                     point,
    npgc_result_if                    result,
    output int                        o_fail_count,
    output int                        o_pending
);
    import npgc_pkg::*;

    typedef struct packed {
        logic [CLASS_W-1:0] nclass;
        logic [NUM_W-1:0]   number;
        logic [DIST_W-1:0]  metres;
    } t_winner;

    localparam longint ONE = 64'sd1073741824;

    longint arc_q30 [32] = '{
        64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76,
        64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD,
        64'h000FFFFF, 64'h0007FFFF, 64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF,
        64'h00007FFF, 64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF,
        64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F, 64'h0000003F,
        64'h0000001F, 64'h0000000F, 64'h00000008, 64'h00000004, 64'h00000002,
        64'h00000001, 64'h00000000
    };

    logic signed [LAT_W-1:0] q_lat;
    logic signed [LON_W-1:0] q_lon;
    logic [DIST_W-1:0]       best_dist;
    logic [CLASS_W-1:0]      best_class;
    logic [NUM_W-1:0]        best_number;
    logic                    have_best;
    t_winner                 winners [$];

    // Rotate to sine and cosine of an angle in degrees * 2^23, Q30
    function automatic void rotate(input longint ang, output longint s, output longint c);
        longint x, y, z, dx, dy;
        bit flip;
        x = 652032874;
        y = 0;
        flip = 0;
        while (ang > 754974720) begin
            ang -= 1509949440;
            flip = !flip;
        end
        while (ang < -754974720) begin
            ang += 1509949440;
            flip = !flip;
        end
        z = (ang >= 0) ? ((ang * 74961321) >>> 25) : -(((-ang) * 74961321) >>> 25);
        for (int i = 0; i < 24; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x -= dx; y += dy; z -= arc_q30[i];
            end else begin
                x += dx; y -= dy; z += arc_q30[i];
            end
        end
        s = flip ? -y : y;
        c = flip ? -x : x;
    endfunction

    function automatic longint root_floor(longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return longint'(r);
    endfunction

    // Haversine distance in metres * 16, saturating
    function automatic logic [DIST_W-1:0] great_circle(longint la1, longint lo1,
                                                       longint la2, longint lo2);
        longint sl, cl, so, co, s1, c1, s2, c2, a, x, y, z, dx, dy;
        longint unsigned p;
        rotate(la2 - la1, sl, cl);
        rotate(lo2 - lo1, so, co);
        rotate(la1 * 2, s1, c1);
        rotate(la2 * 2, s2, c2);
        a = ((sl * sl) >>> 30) + ((((c1 * c2) >>> 30) * ((so * so) >>> 30)) >>> 30);
        if (a < 0) a = 0;
        if (a > ONE) a = ONE;
        x = root_floor(longint'(ONE - a) << 30);
        y = root_floor(longint'(a) << 30);
        z = 0;
        for (int i = 0; i < 24; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y >= 0) begin
                x += dx; y -= dy; z += arc_q30[i];
            end else begin
                x -= dx; y += dy; z -= arc_q30[i];
            end
        end
        if (z < 0) z = 0;
        p = unsigned'(z * 64'sd203872000 + 64'sd536870912);
        p >>= 30;
        return (p > 64'd536870911) ? {DIST_W{1'b1}} : p[DIST_W-1:0];
    endfunction

    always @(posedge i_clk) begin
        logic [DIST_W-1:0] d;
        t_winner w;
        if (!i_rst_n) begin
            q_lat <= '0;
            q_lon <= '0;
            best_dist = '1;
            best_class = '0;
            best_number = '0;
            have_best = 0;
            o_fail_count <= 0;
            o_pending <= 0;
        end else begin
            // Track query registers
            if (i_cfg_wr_en) begin
                if (i_cfg_index == REG_QUERY_LATITUDE) q_lat <= i_cfg_data[LAT_W-1:0];
                else q_lon <= i_cfg_data[LON_W-1:0];
            end
            // Fold an accepted candidate word into the search
            if (point.valid && point.ready) begin
                d = great_circle(point.point_latitude, point.point_longitude,
                                 q_lat, q_lon);
                if (!have_best || d < best_dist) begin
                    best_dist = d;
                    best_class = point.point_class;
                    best_number = point.point_number;
                    have_best = 1;
                end
                if (point.final_point) begin
                    winners.push_back('{best_class, best_number, best_dist});
                    best_dist = '1;
                    best_class = '0;
                    best_number = '0;
                    have_best = 0;
                end
            end
            // Compare a result word with the oldest winner
            if (result.valid && result.ready) begin
                if (winners.size() == 0) begin
                    $display("%0t: unexpected result class %0d number %0d distance %0d",
                             $time, result.nearest_class, result.nearest_number,
                             result.nearest_distance);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    w = winners.pop_front();
                    if (w.nclass !== result.nearest_class ||
                        w.number !== result.nearest_number ||
                        w.metres !== result.nearest_distance) begin
                        $display("%0t: mismatch expected %0d/%0d/%0d actual %0d/%0d/%0d",
                                 $time, w.nclass, w.number, w.metres,
                                 result.nearest_class, result.nearest_number,
                                 result.nearest_distance);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
            o_pending <= winners.size();
        end
    end

endmodule

/* tb/sv/tb_nearest_point_great_circle.sv */
`timescale 1ns / 1ps
// Stimulus and verdict for the nearest point search: drives query settings
// and candidate words. Depends on npgc_pkg, both interfaces and npgc_scoreboard.
module tb_nearest_point_great_circle;
    import npgc_pkg::*;

    localparam int WATCHDOG = 20000;

    logic             i_clk = 0;
    logic             i_rst_n = 0;
    logic             i_cfg_wr_en = 0;
    logic [0:0]       i_cfg_index = REG_QUERY_LATITUDE;
    logic [CFG_W-1:0] i_cfg_data = '0;
    int               fail_count;
    int               pending;
    int               idle_cycles = 0;
    bit               calm = 0;
    int               sent = 0;

    npgc_point_if  point_ch ();
    npgc_result_if result_ch ();

    nearest_point_great_circle DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_wr_en(i_cfg_wr_en),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .i_point(point_ch.sink), .o_result(result_ch.source)
    );

    npgc_scoreboard checker_u (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_wr_en(i_cfg_wr_en),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .point(point_ch), .result(result_ch),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    always #5 i_clk = ~i_clk;

    initial begin
        point_ch.valid = 0;
        point_ch.point_latitude = '0;
        point_ch.point_longitude = '0;
        point_ch.point_class = '0;
        point_ch.point_number = '0;
        point_ch.final_point = 0;
        result_ch.ready = 0;
    end

    // Receiver: ready with random stall bursts, none in the calm stretch
    always @(posedge i_clk) begin
        int n;
        if (!calm && $urandom_range(0, 5) == 0) begin
            n = $urandom_range(1, 9);
            result_ch.ready <= 0;
            repeat (n) @(posedge i_clk);
            result_ch.ready <= 1;
        end else begin
            result_ch.ready <= 1;
        end
    end

    // Watchdog on cycles without any accepted word
    always @(posedge i_clk) begin
        if ((point_ch.valid && point_ch.ready) || (result_ch.valid && result_ch.ready) ||
            !i_rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCHDOG) begin
            $display("nearest_point_great_circle regression: fail");
            $finish;
        end
    end

    task automatic write_reg(input logic [0:0] idx, input logic [CFG_W-1:0] val);
        i_cfg_wr_en <= 1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_wr_en <= 0;
        @(posedge i_clk);
    endtask

    // Drop valid, drain the block, then wait out an engine still busy on non-final words
    task automatic settle();
        point_ch.valid <= 0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
    endtask

    task automatic send(input logic signed [LAT_W-1:0] la, input logic signed [LON_W-1:0] lo,
                        input logic [CLASS_W-1:0] cl, input logic [NUM_W-1:0] num,
                        input logic fin);
        int n;
        if (!calm && $urandom_range(0, 4) == 0) begin
            n = $urandom_range(1, 9);
            point_ch.valid <= 0;
            repeat (n) @(posedge i_clk);
        end
        point_ch.valid <= 1;
        point_ch.point_latitude <= la;
        point_ch.point_longitude <= lo;
        point_ch.point_class <= cl;
        point_ch.point_number <= num;
        point_ch.final_point <= fin;
        @(posedge i_clk);
        while (!point_ch.ready) @(posedge i_clk);
        sent++;
    endtask

    function automatic logic [LAT_W-1:0] any_lat();
        case ($urandom_range(0, 5))
            0: return 30'($urandom);
            1: return 30'sd377487360;
            2: return -30'sd377487360;
            default: return 30'($urandom_range(0, 754974720) - 377487360);
        endcase
    endfunction

    function automatic logic [LON_W-1:0] any_lon();
        case ($urandom_range(0, 5))
            0: return 31'($urandom);
            1: return 31'sd754974720;
            2: return -31'sd754974720;
            default: return 31'($urandom_range(0, 1509949440) - 754974720);
        endcase
    endfunction

    initial begin
        int len;
        logic signed [LAT_W-1:0] la;
        logic signed [LON_W-1:0] lo;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // Directed: reset query, extremes, ties, saturated-looking far points
        send(30'sd0, 31'sd0, 2'd0, 16'd0, 1'b1);
        send(30'sd377487360, 31'sd754974720, 2'd2, 16'hFFFF, 1'b0);
        send(-30'sd377487360, -31'sd754974720, 2'd1, 16'h1234, 1'b0);
        send(30'sd0, 31'sd754974720, 2'd2, 16'h0001, 1'b1);
        send(30'sd1000, 31'sd1000, 2'd1, 16'd5, 1'b0);
        send(30'sd1000, 31'sd1000, 2'd2, 16'd6, 1'b1);
        send(30'h1FFFFFFF, 31'h3FFFFFFF, 2'd3, 16'hAAAA, 1'b0);
        send(30'h20000000, 31'h40000000, 2'd3, 16'h5555, 1'b1);
        settle();
        write_reg(REG_QUERY_LATITUDE, 31'(30'sd377487360));
        write_reg(REG_QUERY_LONGITUDE, 31'sh40000000);
        send(-30'sd377487360, 31'sd0, 2'd1, 16'd7, 1'b1);
        send(30'sd377487360, -31'sd754974720, 2'd0, 16'd8, 1'b0);
        send(30'sd377487360, 31'sd754974720, 2'd2, 16'd9, 1'b1);
        settle();
        write_reg(REG_QUERY_LATITUDE, 31'(-30'sd377487360));
        write_reg(REG_QUERY_LONGITUDE, 31'sd754974720);
        send(30'sd377487360, 31'sd0, 2'd2, 16'd10, 1'b1);
        send(-30'sd377487360, 31'sd754974720, 2'd1, 16'd11, 1'b1);

        // Random searches of short runs under several query settings
        while (sent < 1000) begin
            settle();
            write_reg(REG_QUERY_LATITUDE, 31'(any_lat()));
            write_reg(REG_QUERY_LONGITUDE, any_lon());
            if (sent > 850) calm = 1;
            repeat ($urandom_range(3, 12)) begin
                len = $urandom_range(1, 6);
                for (int k = 0; k < len; k++) begin
                    la = any_lat();
                    lo = any_lon();
                    send(la, lo, 2'($urandom_range(0, 3)), 16'($urandom), k == len - 1);
                    if ($urandom_range(0, 3) == 0)
                        send(la, lo, 2'($urandom_range(0, 3)), 16'($urandom), 1'b0);
                end
            end
        end

        settle();
        if (fail_count == 0)
            $display("nearest_point_great_circle regression: pass");
        else
            $display("nearest_point_great_circle regression: fail");
        $finish;
    end

endmodule

/* sim.f */
design/npgc_pkg.sv
design/npgc_point_if.sv
design/npgc_result_if.sv
design/npgc_front.sv
design/npgc_queue.sv
design/npgc_back.sv
design/nearest_point_great_circle.sv
tb/sv/npgc_scoreboard.sv
tb/sv/tb_nearest_point_great_circle.sv
